### sv/psrg_pkg.sv
// ----------------------------------------------------------------------------
// psrg_pkg
// Shared types and constants for the polar sector range point gate: register
// codes, azimuth constants and the arctangent table of the rotation cells.
// ----------------------------------------------------------------------------
package psrg_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int ANGLE_STAGES_DEF = 16;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int AZ_BITS       = 15;
  localparam int RANGE_BITS    = 16;
  localparam int LEVEL_BITS    = 16;

  // angle accumulator in 1/65536 degree
  localparam int ZW = 26;
  localparam int HALF_TURN = 11796480;
  localparam int AZ_LIMIT  = 11520;
  localparam int AZ_ROUND  = 512;
  localparam int AZ_SHIFT  = 10;

  localparam logic signed [AZ_BITS-1:0] AZ_LOW_RST   = -15'sd7680;
  localparam logic signed [AZ_BITS-1:0] AZ_HIGH_RST  = 15'sd7680;
  localparam logic [RANGE_BITS-1:0]     RANGE_LOW_RST  = 16'd320;
  localparam logic [RANGE_BITS-1:0]     RANGE_HIGH_RST = 16'd1920;

  localparam int ATAN_LEN = 24;
  localparam int ATAN_TAB [0:ATAN_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_AZ_LOW     = 2'd0,
    REG_AZ_HIGH    = 2'd1,
    REG_RANGE_LOW  = 2'd2,
    REG_RANGE_HIGH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [LEVEL_BITS-1:0] level;
  } tag_t;

endpackage

### sv/psrg_entry.sv
// ----------------------------------------------------------------------------
// psrg_entry
// Front cell: registers a point, folds the left half plane onto the right
// one for the rotation chain and forms the squares of the coordinates.
// ----------------------------------------------------------------------------
module psrg_entry #(
  parameter int COORD_BITS = psrg_pkg::COORD_BITS_DEF,
  parameter int XW         = psrg_pkg::COORD_BITS_DEF + 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [COORD_BITS-1:0]     pos_x,
  input  logic signed [COORD_BITS-1:0]     pos_y,
  input  logic signed [COORD_BITS-1:0]     pos_z,
  input  logic [psrg_pkg::LEVEL_BITS-1:0]  echo_level,
  input  logic                             final_point,
  output psrg_pkg::tag_t                   tag,
  output logic signed [XW-1:0]             rx,
  output logic signed [XW-1:0]             ry,
  output logic signed [psrg_pkg::ZW-1:0]   rz,
  output logic signed [COORD_BITS-1:0]     px,
  output logic signed [COORD_BITS-1:0]     py,
  output logic signed [COORD_BITS-1:0]     pz,
  output logic [2*COORD_BITS-1:0]          sx,
  output logic [2*COORD_BITS-1:0]          sy,
  output logic [2*COORD_BITS-1:0]          sz
);
  import psrg_pkg::*;

  logic signed [XW-1:0]           gx;
  logic signed [XW-1:0]           gy;
  logic signed [2*COORD_BITS-1:0] qx;
  logic signed [2*COORD_BITS-1:0] qy;
  logic signed [2*COORD_BITS-1:0] qz;

  // scale by 256 for guard bits
  assign gx = XW'(pos_x) <<< 8;
  assign gy = XW'(pos_y) <<< 8;

  assign qx = pos_x * pos_x;
  assign qy = pos_y * pos_y;
  assign qz = pos_z * pos_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= start;
    end
    tag.last  <= final_point;
    tag.level <= echo_level;
    px <= pos_x;
    py <= pos_y;
    pz <= pos_z;
    sx <= qx;
    sy <= qy;
    sz <= qz;
    if (pos_x[COORD_BITS-1]) begin
      rx <= -gx;
      ry <= -gy;
      rz <= pos_y[COORD_BITS-1] ? -ZW'(HALF_TURN) : ZW'(HALF_TURN);
    end else begin
      rx <= gx;
      ry <= gy;
      rz <= '0;
    end
  end

endmodule

### sv/psrg_cordic_cell.sv
// ----------------------------------------------------------------------------
// psrg_cordic_cell
// One vectoring rotation step: turns the vector toward the x axis by the
// arctangent of its stage and hands the point on to the next cell.
// ----------------------------------------------------------------------------
module psrg_cordic_cell #(
  parameter int COORD_BITS = psrg_pkg::COORD_BITS_DEF,
  parameter int XW         = psrg_pkg::COORD_BITS_DEF + 11,
  parameter int STAGE      = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  psrg_pkg::tag_t                  in_tag,
  input  logic signed [XW-1:0]            in_rx,
  input  logic signed [XW-1:0]            in_ry,
  input  logic signed [psrg_pkg::ZW-1:0]  in_rz,
  input  logic signed [COORD_BITS-1:0]    in_px,
  input  logic signed [COORD_BITS-1:0]    in_py,
  input  logic signed [COORD_BITS-1:0]    in_pz,
  input  logic [2*COORD_BITS-1:0]         in_sx,
  input  logic [2*COORD_BITS-1:0]         in_sy,
  input  logic [2*COORD_BITS-1:0]         in_sz,
  output psrg_pkg::tag_t                  tag,
  output logic signed [XW-1:0]            rx,
  output logic signed [XW-1:0]            ry,
  output logic signed [psrg_pkg::ZW-1:0]  rz,
  output logic signed [COORD_BITS-1:0]    px,
  output logic signed [COORD_BITS-1:0]    py,
  output logic signed [COORD_BITS-1:0]    pz,
  output logic [2*COORD_BITS-1:0]         sx,
  output logic [2*COORD_BITS-1:0]         sy,
  output logic [2*COORD_BITS-1:0]         sz
);
  import psrg_pkg::*;

  localparam logic signed [ZW-1:0] STEP_ANGLE = ZW'(ATAN_TAB[STAGE]);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] rx_next;
  logic signed [XW-1:0] ry_next;
  logic signed [ZW-1:0] rz_next;

  assign xs = in_rx >>> STAGE;
  assign ys = in_ry >>> STAGE;

  always_comb begin
    rx_next = in_rx;
    ry_next = in_ry;
    rz_next = in_rz;
    if (!in_ry[XW-1] && (|in_ry)) begin
      rx_next = in_rx + ys;
      ry_next = in_ry - xs;
      rz_next = in_rz + STEP_ANGLE;
    end else if (in_ry[XW-1]) begin
      rx_next = in_rx - ys;
      ry_next = in_ry + xs;
      rz_next = in_rz - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= in_tag.valid;
    end
    tag.last  <= in_tag.last;
    tag.level <= in_tag.level;
    rx <= rx_next;
    ry <= ry_next;
    rz <= rz_next;
    px <= in_px;
    py <= in_py;
    pz <= in_pz;
    sx <= in_sx;
    sy <= in_sy;
    sz <= in_sz;
  end

endmodule

### sv/psrg_decide.sv
// ----------------------------------------------------------------------------
// psrg_decide
// Last cell: rounds the angle to 1/64 degree, sums the squared distance,
// checks both windows and registers the result item.
// ----------------------------------------------------------------------------
module psrg_decide #(
  parameter int COORD_BITS = psrg_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  psrg_pkg::tag_t                        in_tag,
  input  logic signed [psrg_pkg::ZW-1:0]        in_rz,
  input  logic signed [COORD_BITS-1:0]          in_px,
  input  logic signed [COORD_BITS-1:0]          in_py,
  input  logic signed [COORD_BITS-1:0]          in_pz,
  input  logic [2*COORD_BITS-1:0]               in_sx,
  input  logic [2*COORD_BITS-1:0]               in_sy,
  input  logic [2*COORD_BITS-1:0]               in_sz,
  input  logic signed [psrg_pkg::AZ_BITS-1:0]   azimuth_low,
  input  logic signed [psrg_pkg::AZ_BITS-1:0]   azimuth_high,
  input  logic [2*psrg_pkg::RANGE_BITS-1:0]     range_low_sq,
  input  logic [2*psrg_pkg::RANGE_BITS-1:0]     range_high_sq,
  output logic                                  out_valid,
  output logic signed [COORD_BITS-1:0]          out_x,
  output logic signed [COORD_BITS-1:0]          out_y,
  output logic signed [COORD_BITS-1:0]          out_z,
  output logic [psrg_pkg::LEVEL_BITS-1:0]       out_level,
  output logic                                  kept,
  output logic                                  frame_end
);
  import psrg_pkg::*;

  localparam int SW = (2*COORD_BITS > 2*RANGE_BITS) ? 2*COORD_BITS : 2*RANGE_BITS;
  localparam int AW = ZW + 1;

  logic signed [AW-1:0]      zs;
  logic signed [AW-1:0]      zr;
  logic signed [AZ_BITS-1:0] az;
  logic [SW-1:0]             d2;
  logic                      keep;

  assign zs = AW'(in_rz) + AW'(AZ_ROUND);
  assign zr = zs >>> AZ_SHIFT;

  always_comb begin
    if (zr > AW'(AZ_LIMIT)) begin
      az = AZ_BITS'(AZ_LIMIT);
    end else if (zr < -AW'(AZ_LIMIT)) begin
      az = -AZ_BITS'(AZ_LIMIT);
    end else begin
      az = zr[AZ_BITS-1:0];
    end
  end

  assign d2   = SW'(in_sx) + SW'(in_sy) + SW'(in_sz);
  assign keep = (az >= azimuth_low) && (az <= azimuth_high) &&
                (d2 >= SW'(range_low_sq)) && (d2 <= SW'(range_high_sq));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_tag.valid && (keep || in_tag.last);
    end
  end

  always_ff @(posedge clk) begin
    kept <= keep;
    frame_end <= in_tag.last;
    if (keep) begin
      out_x     <= in_px;
      out_y     <= in_py;
      out_z     <= in_pz;
      out_level <= in_tag.level;
    end else begin
      out_x     <= '0;
      out_y     <= '0;
      out_z     <= '0;
      out_level <= '0;
    end
  end

endmodule

### sv/polar_sector_range_point_gate.sv
// ----------------------------------------------------------------------------
// polar_sector_range_point_gate
// Keeps radar points whose distance and azimuth fall inside configured
// inclusive windows; a dropped last point still yields an end marker.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+-----------------------
//  point in | start, busy, pos_x/y/z, echo_level,       | start high, busy low
//           | final_point                               |
//  result   | out_valid, out_x/y/z, out_level, kept,    | out_valid high, one
//           | frame_end                                 | cycle, never held off
//  config   | cfg_we, cfg_index, cfg_data               | cfg_we high
//
//  one point per cycle while busy is low; each result passes the entry
//  cell, one rotation cell per angle stage and the decision register.
//  busy is high only during reset; no clearing pass.
//  reset restores the window registers and empties the cell chain.
// ----------------------------------------------------------------------------
module polar_sector_range_point_gate #(
  parameter int COORD_BITS   = psrg_pkg::COORD_BITS_DEF,
  parameter int ANGLE_STAGES = psrg_pkg::ANGLE_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_BITS-1:0]         pos_x,
  input  logic signed [COORD_BITS-1:0]         pos_y,
  input  logic signed [COORD_BITS-1:0]         pos_z,
  input  logic [psrg_pkg::LEVEL_BITS-1:0]      echo_level,
  input  logic                                 final_point,
  output logic                                 out_valid,
  output logic signed [COORD_BITS-1:0]         out_x,
  output logic signed [COORD_BITS-1:0]         out_y,
  output logic signed [COORD_BITS-1:0]         out_z,
  output logic [psrg_pkg::LEVEL_BITS-1:0]      out_level,
  output logic                                 kept,
  output logic                                 frame_end,
  input  logic                                 cfg_we,
  input  logic [psrg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [psrg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import psrg_pkg::*;

  localparam int XW = COORD_BITS + 11;

  logic signed [AZ_BITS-1:0]  azimuth_low;
  logic signed [AZ_BITS-1:0]  azimuth_high;
  logic [RANGE_BITS-1:0]      range_low;
  logic [RANGE_BITS-1:0]      range_high;
  logic [2*RANGE_BITS-1:0]    range_low_sq;
  logic [2*RANGE_BITS-1:0]    range_high_sq;

  tag_t                       c_tag [0:ANGLE_STAGES];
  logic signed [XW-1:0]       c_rx  [0:ANGLE_STAGES];
  logic signed [XW-1:0]       c_ry  [0:ANGLE_STAGES];
  logic signed [ZW-1:0]       c_rz  [0:ANGLE_STAGES];
  logic signed [COORD_BITS-1:0] c_px [0:ANGLE_STAGES];
  logic signed [COORD_BITS-1:0] c_py [0:ANGLE_STAGES];
  logic signed [COORD_BITS-1:0] c_pz [0:ANGLE_STAGES];
  logic [2*COORD_BITS-1:0]    c_sx  [0:ANGLE_STAGES];
  logic [2*COORD_BITS-1:0]    c_sy  [0:ANGLE_STAGES];
  logic [2*COORD_BITS-1:0]    c_sz  [0:ANGLE_STAGES];

  assign busy = rst;

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      azimuth_low  <= AZ_LOW_RST;
      azimuth_high <= AZ_HIGH_RST;
      range_low    <= RANGE_LOW_RST;
      range_high   <= RANGE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_AZ_LOW:     azimuth_low  <= cfg_data[AZ_BITS-1:0];
        REG_AZ_HIGH:    azimuth_high <= cfg_data[AZ_BITS-1:0];
        REG_RANGE_LOW:  range_low    <= cfg_data[RANGE_BITS-1:0];
        REG_RANGE_HIGH: range_high   <= cfg_data[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    range_low_sq  <= range_low * range_low;
    range_high_sq <= range_high * range_high;
  end

  psrg_entry #(
    .COORD_BITS (COORD_BITS),
    .XW         (XW)
  ) u_entry (
    .clk         (clk),
    .rst         (rst),
    .start       (start && !busy),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .echo_level  (echo_level),
    .final_point (final_point),
    .tag         (c_tag[0]),
    .rx          (c_rx[0]),
    .ry          (c_ry[0]),
    .rz          (c_rz[0]),
    .px          (c_px[0]),
    .py          (c_py[0]),
    .pz          (c_pz[0]),
    .sx          (c_sx[0]),
    .sy          (c_sy[0]),
    .sz          (c_sz[0])
  );

  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cell
    psrg_cordic_cell #(
      .COORD_BITS (COORD_BITS),
      .XW         (XW),
      .STAGE      (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .in_tag (c_tag[i]),
      .in_rx  (c_rx[i]),
      .in_ry  (c_ry[i]),
      .in_rz  (c_rz[i]),
      .in_px  (c_px[i]),
      .in_py  (c_py[i]),
      .in_pz  (c_pz[i]),
      .in_sx  (c_sx[i]),
      .in_sy  (c_sy[i]),
      .in_sz  (c_sz[i]),
      .tag    (c_tag[i+1]),
      .rx     (c_rx[i+1]),
      .ry     (c_ry[i+1]),
      .rz     (c_rz[i+1]),
      .px     (c_px[i+1]),
      .py     (c_py[i+1]),
      .pz     (c_pz[i+1]),
      .sx     (c_sx[i+1]),
      .sy     (c_sy[i+1]),
      .sz     (c_sz[i+1])
    );
  end

  psrg_decide #(
    .COORD_BITS (COORD_BITS)
  ) u_decide (
    .clk           (clk),
    .rst           (rst),
    .in_tag        (c_tag[ANGLE_STAGES]),
    .in_rz         (c_rz[ANGLE_STAGES]),
    .in_px         (c_px[ANGLE_STAGES]),
    .in_py         (c_py[ANGLE_STAGES]),
    .in_pz         (c_pz[ANGLE_STAGES]),
    .in_sx         (c_sx[ANGLE_STAGES]),
    .in_sy         (c_sy[ANGLE_STAGES]),
    .in_sz         (c_sz[ANGLE_STAGES]),
    .azimuth_low   (azimuth_low),
    .azimuth_high  (azimuth_high),
    .range_low_sq  (range_low_sq),
    .range_high_sq (range_high_sq),
    .out_valid     (out_valid),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_level     (out_level),
    .kept          (kept),
    .frame_end     (frame_end)
  );

endmodule
